/* design/vary_header_store_classifier_core_assert.svh */
// Assertion macros used by the checker file of the Vary classifier.
`ifndef VARY_HEADER_STORE_CLASSIFIER_CORE_ASSERT_SVH
`define VARY_HEADER_STORE_CLASSIFIER_CORE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define VHSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vhsc assertion failed");

// Property checked at every clock edge, reset included.
`define VHSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vhsc assertion failed");

`endif

/* design/vhsc_pkg.sv */
// Types, constants and name tables of the Vary value classifier.
package vhsc_pkg;

    localparam int NAME_COUNT = 4;
    localparam int POS_W      = 5;
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        NAME_ACCEPT_ENCODING = 2'd0,
        NAME_USER_AGENT      = 2'd1,
        NAME_ACCEPT          = 2'd2,
        NAME_SAVE_DATA       = 2'd3
    } vhsc_name_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } vhsc_item_t;

    typedef struct packed {
        logic storable;
        logic accept_vary;
        logic uncacheable;
    } vhsc_verdict_t;

    typedef struct packed {
        logic [POS_W-1:0]      name_position;
        logic [NAME_COUNT-1:0] candidate_mask;
        logic                  token_started;
        logic                  gap_after_text;
        logic                  star_only;
        logic                  refused;
        logic                  accept_seen;
    } vhsc_state_t;

    localparam vhsc_state_t STATE_RESET = '{
        name_position:  '0,
        candidate_mask: '1,
        token_started:  1'b0,
        gap_after_text: 1'b0,
        star_only:      1'b0,
        refused:        1'b0,
        accept_seen:    1'b0
    };

    function automatic logic [POS_W-1:0] name_len(input vhsc_name_t idx);
        logic [POS_W-1:0] len;
        case (idx)
            NAME_ACCEPT_ENCODING: len = 5'd15;
            NAME_USER_AGENT:      len = 5'd10;
            NAME_ACCEPT:          len = 5'd6;
            NAME_SAVE_DATA:       len = 5'd9;
            default:              len = '0;
        endcase
        return len;
    endfunction

    // Lower-case name text, first character in the top byte.
    function automatic logic [7:0] name_byte(input vhsc_name_t idx, input logic [3:0] pos);
        logic [127:0] text;
        case (idx)
            NAME_ACCEPT_ENCODING: text = {"accept-encoding", 8'h00};
            NAME_USER_AGENT:      text = {"user-agent", 48'h0};
            NAME_ACCEPT:          text = {"accept", 80'h0};
            NAME_SAVE_DATA:       text = {"save-data", 56'h0};
            default:              text = '0;
        endcase
        return text[(15 - int'(pos)) * 8 +: 8];
    endfunction

endpackage

/* design/vhsc_step.sv */
// Next-state and verdict logic for one byte of a Vary value.
module vhsc_step
    import vhsc_pkg::*;
(
    input  vhsc_state_t   state,
    input  vhsc_item_t    item,
    output vhsc_state_t   state_next,
    output vhsc_verdict_t verdict
);

    logic [7:0]            folded;
    logic [NAME_COUNT-1:0] keep;
    logic                  blank;
    vhsc_state_t           taken;
    vhsc_state_t           closed;

    // Close the current member: judge it, then clear the member fields.
    function automatic vhsc_state_t end_member(input vhsc_state_t s);
        vhsc_state_t           r;
        logic [NAME_COUNT-1:0] hit;
        r = s;
        for (int i = 0; i < NAME_COUNT; i++) begin
            hit[i] = s.candidate_mask[i]
                && (s.name_position == name_len(vhsc_name_t'(2'(i))));
        end
        if (s.token_started && !s.refused) begin
            if (s.star_only || hit == '0) begin
                r.refused     = 1'b1;
                r.accept_seen = 1'b0;
            end
            else if (hit[NAME_ACCEPT]) begin
                r.accept_seen = 1'b1;
            end
        end
        r.name_position  = '0;
        r.candidate_mask = '1;
        r.token_started  = 1'b0;
        r.gap_after_text = 1'b0;
        r.star_only      = 1'b0;
        return r;
    endfunction

    assign folded = (item.ch >= UPPER_A && item.ch <= UPPER_Z) ? (item.ch | CASE_BIT) : item.ch;
    assign blank  = (item.ch == CH_SPACE) || (item.ch == CH_TAB);

    always_comb
    begin
        for (int i = 0; i < NAME_COUNT; i++) begin
            keep[i] = (state.name_position < name_len(vhsc_name_t'(2'(i))))
                && (name_byte(vhsc_name_t'(2'(i)), state.name_position[3:0]) == folded);
        end
    end

    always_comb
    begin
        taken = state;
        if (item.has_char && !state.refused) begin
            if (item.ch == CH_COMMA) begin
                taken = end_member(state);
            end
            else if (blank) begin
                if (state.token_started) begin
                    taken.gap_after_text = 1'b1;
                end
            end
            else if (state.gap_after_text) begin
                // text after a blank inside a member
                taken.refused     = 1'b1;
                taken.accept_seen = 1'b0;
            end
            else begin
                taken.token_started  = 1'b1;
                taken.star_only      = !state.token_started && (item.ch == CH_STAR);
                taken.candidate_mask = state.candidate_mask & keep;
                if (state.name_position != POS_MAX) begin
                    taken.name_position = state.name_position + 1'b1;
                end
            end
        end
        closed = end_member(taken);
    end

    assign verdict.storable      = !closed.refused;
    assign verdict.accept_vary   = !closed.refused && closed.accept_seen;
    assign verdict.uncacheable   = closed.refused;
    assign state_next            = item.last ? STATE_RESET : taken;

endmodule

/* design/vary_header_store_classifier_core.sv */
// Top level of the Vary value storability classifier.
//
//  channel   signals                                    payload
//  bytes     byte_valid / byte_stall / byte_data        ch, has_char, last
//  verdicts  verdict_valid / verdict_stall / verdict_data storable, accept_vary, uncacheable
//
// One byte request is taken per cycle while byte_stall is low; the scan state updates as each byte fires.
// A verdict is offered once its last byte has passed item_reg and the verdict is registered in verdict_reg.
// Reset clears the scan state to "no member, nothing refused" and empties both registers.
// Only a byte that ends a value waits while a verdict is held by verdict_stall;
// other bytes keep flowing.
module vary_header_store_classifier_core
    import vhsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  vhsc_item_t    byte_data,
    output logic          verdict_valid,
    input  logic          verdict_stall,
    output vhsc_verdict_t verdict_data
);

    vhsc_item_t    item_reg;
    logic          item_valid_reg;
    vhsc_state_t   state_reg;
    vhsc_state_t   state_next;
    vhsc_verdict_t verdict;
    vhsc_verdict_t verdict_reg;
    logic          verdict_valid_reg;
    logic          fire;
    logic          take;

    vhsc_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .verdict    (verdict)
    );

    // a byte that carries no verdict never waits for the output register
    assign fire = item_valid_reg
        && (!item_reg.last || !verdict_valid_reg || !verdict_stall);
    assign byte_stall = item_valid_reg && !fire;
    assign take       = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg    <= 1'b0;
            verdict_valid_reg <= 1'b0;
            state_reg         <= STATE_RESET;
        end
        else begin
            if (take) begin
                item_valid_reg <= 1'b1;
            end
            else if (fire) begin
                item_valid_reg <= 1'b0;
            end
            if (fire) begin
                state_reg <= state_next;
            end
            if (fire && item_reg.last) begin
                verdict_valid_reg <= 1'b1;
            end
            else if (!verdict_stall) begin
                verdict_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            item_reg <= byte_data;
        end
        if (fire && item_reg.last) begin
            verdict_reg <= verdict;
        end
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict_data  = verdict_reg;

endmodule

/* design/vhsc_checker.sv */
// Port-level checks on the Vary classifier, bound to its top level.
`include "vary_header_store_classifier_core_assert.svh"

module vhsc_checker
    import vhsc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          byte_valid,
    input logic          byte_stall,
    input vhsc_item_t    byte_data,
    input logic          verdict_valid,
    input logic          verdict_stall,
    input vhsc_verdict_t verdict_data
);

    logic byte_waiting;
    logic verdict_split;
    logic accept_ok;

    assign byte_waiting  = byte_valid && byte_stall;
    // exactly one of storable and uncacheable
    assign verdict_split = verdict_data.storable ^ verdict_data.uncacheable;
    assign accept_ok     = !verdict_data.accept_vary || verdict_data.storable;

    `VHSC_ASSERT_ALWAYS(a_no_verdict_in_reset, clk, !rst_n |=> !verdict_valid)
    `VHSC_ASSERT(a_verdict_held, clk, rst_n, verdict_valid && verdict_stall |=> verdict_valid)
    `VHSC_ASSERT(a_request_held, clk, rst_n, byte_waiting |=> byte_valid && $stable(byte_data))
    `VHSC_ASSERT(a_refusal_exclusive, clk, rst_n, verdict_valid |-> verdict_split)
    `VHSC_ASSERT(a_accept_needs_store, clk, rst_n, verdict_valid |-> accept_ok)

endmodule

bind vary_header_store_classifier_core vhsc_checker u_vhsc_checker (.*);
